// ----- rtl/emac_pkg.sv -----
package emac_pkg;

    // default build parameters
    localparam int SAMPLE_BITS_DEF      = 10;
    localparam int FILTER_FRAC_BITS_DEF = 16;

    // calibration register widths
    localparam int ADC_CAL_W  = 11;
    localparam int PSI_CAL_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // filter weights, 16 fractional bits
    localparam int                       MUL_B_W      = 17;
    localparam logic signed [MUL_B_W-1:0] ALPHA_Q     = 17'sd62259;
    localparam logic signed [MUL_B_W-1:0] BETA_Q      = 17'sd3277;
    localparam int                       WEIGHT_SHIFT = 16;

    // pressure output format
    localparam int Q8_W   = 24;
    localparam int Q8_MAX = 8388607;
    localparam int Q8_MIN = -8388608;

    // calibration register reset values
    localparam logic [ADC_CAL_W-1:0]        ADC_LOW_RST  = 11'd0;
    localparam logic signed [PSI_CAL_W-1:0] PSI_LOW_RST  = 12'sd0;
    localparam logic [ADC_CAL_W-1:0]        ADC_HIGH_RST = 11'd1024;
    localparam logic signed [PSI_CAL_W-1:0] PSI_HIGH_RST = 12'sd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_LOW  = 2'd0,
        CFG_PSI_LOW  = 2'd1,
        CFG_ADC_HIGH = 2'd2,
        CFG_PSI_HIGH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_CAL_W-1:0]        adc_low;
        logic signed [PSI_CAL_W-1:0] psi_low;
        logic [ADC_CAL_W-1:0]        adc_high;
        logic signed [PSI_CAL_W-1:0] psi_high;
    } t_cal;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_LEVEL,
        ST_MUL_CAL,
        ST_PREP,
        ST_DIV,
        ST_FINAL,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_OLD,
        OP_MUL_NEW,
        OP_LEVEL,
        OP_MUL_CAL,
        OP_PREP,
        OP_DIV,
        OP_FINAL
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_sample;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic calib_err;
    } t_stat;

    // signed width of level minus the scaled low calibration reading
    function automatic int off_bits(input int sb, input int ff);
        int lw;
        int afw;
        lw  = sb + ff;
        afw = ADC_CAL_W + ff;
        return ((lw > afw) ? lw : afw) + 1;
    endfunction

    // quotient bits of the pre-shifted rounding divide
    function automatic int quo_bits(input int sb, input int ff);
        return off_bits(sb, ff) + PSI_CAL_W + 1 - (ff - 8);
    endfunction

endpackage

// ----- rtl/emac_mul.sv -----
module emac_mul #(
    parameter int A_W = emac_pkg::off_bits(emac_pkg::SAMPLE_BITS_DEF,
                                           emac_pkg::FILTER_FRAC_BITS_DEF),
    parameter int B_W = emac_pkg::MUL_B_W
) (
    input  logic                     i_clk,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;
    logic signed [A_W+B_W-1:0] n_prod;

    always_comb begin
        n_prod = (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/emac_ctrl.sv -----
module emac_ctrl #(
    parameter int SAMPLE_BITS      = emac_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = emac_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    input  emac_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output emac_pkg::t_ctrl o_ctrl
);

    localparam int DVW  = emac_pkg::quo_bits(SAMPLE_BITS, FILTER_FRAC_BITS);
    localparam int CNTW = $clog2(DVW);

    emac_pkg::t_state r_state;
    emac_pkg::t_state n_state;
    logic [CNTW-1:0]  r_cnt;
    logic [CNTW-1:0]  n_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emac_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = emac_pkg::ST_MUL_OLD;
                end
            end
            emac_pkg::ST_MUL_OLD: n_state = emac_pkg::ST_MUL_NEW;
            emac_pkg::ST_MUL_NEW: n_state = emac_pkg::ST_LEVEL;
            emac_pkg::ST_LEVEL: begin
                if (i_stat.calib_err) begin
                    n_state = emac_pkg::ST_DONE;
                end else begin
                    n_state = emac_pkg::ST_MUL_CAL;
                end
            end
            emac_pkg::ST_MUL_CAL: n_state = emac_pkg::ST_PREP;
            emac_pkg::ST_PREP:    n_state = emac_pkg::ST_DIV;
            emac_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = emac_pkg::ST_FINAL;
                end
            end
            emac_pkg::ST_FINAL: n_state = emac_pkg::ST_DONE;
            emac_pkg::ST_DONE: begin
                if (!i_out_busy) begin
                    n_state = emac_pkg::ST_IDLE;
                end
            end
            default: n_state = emac_pkg::ST_IDLE;
        endcase
    end

    // divide step counter
    always_comb begin
        n_cnt = r_cnt;
        if (r_state == emac_pkg::ST_PREP) begin
            n_cnt = CNTW'(DVW - 1);
        end else if (r_state == emac_pkg::ST_DIV) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_comb begin
        o_ctrl.op          = emac_pkg::OP_NONE;
        o_ctrl.load_sample = 1'b0;
        o_ctrl.load_out    = 1'b0;
        o_in_stall         = 1'b1;
        unique case (r_state)
            emac_pkg::ST_IDLE: begin
                o_in_stall         = 1'b0;
                o_ctrl.load_sample = i_in_valid;
            end
            emac_pkg::ST_MUL_OLD: o_ctrl.op = emac_pkg::OP_MUL_OLD;
            emac_pkg::ST_MUL_NEW: o_ctrl.op = emac_pkg::OP_MUL_NEW;
            emac_pkg::ST_LEVEL:   o_ctrl.op = emac_pkg::OP_LEVEL;
            emac_pkg::ST_MUL_CAL: o_ctrl.op = emac_pkg::OP_MUL_CAL;
            emac_pkg::ST_PREP:    o_ctrl.op = emac_pkg::OP_PREP;
            emac_pkg::ST_DIV:     o_ctrl.op = emac_pkg::OP_DIV;
            emac_pkg::ST_FINAL:   o_ctrl.op = emac_pkg::OP_FINAL;
            emac_pkg::ST_DONE:    o_ctrl.load_out = !i_out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= emac_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/emac_dp.sv -----
module emac_dp #(
    parameter int SAMPLE_BITS      = emac_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = emac_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  emac_pkg::t_ctrl                              i_ctrl,
    input  emac_pkg::t_cal                               i_cal,
    input  logic [SAMPLE_BITS-1:0]                       i_adc_sample,
    output emac_pkg::t_stat                              o_stat,
    output logic [SAMPLE_BITS-1:0]                       o_sample,
    output logic [SAMPLE_BITS+FILTER_FRAC_BITS-1:0]      o_level,
    output logic signed [emac_pkg::Q8_W-1:0]             o_press,
    output logic                                         o_err
);

    localparam int LW  = SAMPLE_BITS + FILTER_FRAC_BITS;
    localparam int AW  = LW + emac_pkg::WEIGHT_SHIFT;
    localparam int OW  = emac_pkg::off_bits(SAMPLE_BITS, FILTER_FRAC_BITS);
    localparam int DPW = emac_pkg::PSI_CAL_W + 1;
    localparam int NW  = OW + DPW;
    localparam int MW  = NW - 1;
    localparam int SH  = FILTER_FRAC_BITS - 8;
    localparam int DVW = emac_pkg::quo_bits(SAMPLE_BITS, FILTER_FRAC_BITS);
    localparam int DDW = emac_pkg::ADC_CAL_W;
    localparam int SW  = DVW + 2;
    localparam int PW  = OW + emac_pkg::MUL_B_W;

    localparam logic [LW-1:0]        LEVEL_RST = LW'(1) << (LW - 1);
    localparam logic [AW-1:0]        ROUND_HALF = AW'(1) << (emac_pkg::WEIGHT_SHIFT - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(emac_pkg::Q8_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(emac_pkg::Q8_MIN);

    logic signed [OW-1:0]               mul_a;
    logic signed [emac_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               prod;

    logic [SAMPLE_BITS-1:0]      r_sample, n_sample;
    logic [LW-1:0]               r_level, n_level;
    logic [AW-1:0]               r_acc, n_acc;
    logic [DDW-1:0]              r_rem, n_rem;
    logic [DVW-1:0]              r_quo, n_quo;
    logic [DDW-1:0]              r_div, n_div;
    logic                        r_neg, n_neg;
    logic signed [emac_pkg::Q8_W-1:0] r_press, n_press;
    logic                        r_err, n_err;

    logic [AW-1:0]               acc_sum;
    logic signed [OW-1:0]        off;
    logic signed [DPW-1:0]       dpsi;
    logic signed [NW-1:0]        num;
    logic [NW-1:0]               num_mag;
    logic signed [DDW:0]         dadc;
    logic [DDW:0]                dadc_mag;
    logic [DDW+SH-1:0]           den_full;
    logic [DDW+SH-1:0]           den_half;
    logic [MW:0]                 num2;
    logic [DDW:0]                rem_sh;
    logic [DDW+1:0]              trial;
    logic signed [SW-1:0]        base;
    logic signed [SW-1:0]        qs;
    logic signed [SW-1:0]        psum;
    logic                        calib_err;

    emac_mul #(
        .A_W (OW),
        .B_W (emac_pkg::MUL_B_W)
    ) u_emac_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign calib_err = (i_cal.adc_low == i_cal.adc_high);

    // filter sum: alpha*old + beta*(sample << frac) + half lsb
    assign acc_sum = r_acc + (AW'(prod[AW-1:0]) << FILTER_FRAC_BITS) + ROUND_HALF;

    // line setup
    assign off  = signed'(OW'(r_level))
                - signed'(OW'({i_cal.adc_low, {FILTER_FRAC_BITS{1'b0}}}));
    assign dpsi = DPW'(i_cal.psi_high) - DPW'(i_cal.psi_low);
    assign num  = signed'(prod[NW-1:0]);
    assign num_mag = num[NW-1] ? unsigned'(-num) : unsigned'(num);
    assign dadc = signed'({1'b0, i_cal.adc_high}) - signed'({1'b0, i_cal.adc_low});
    assign dadc_mag = dadc[DDW] ? unsigned'(-dadc) : unsigned'(dadc);
    assign den_full = (DDW+SH)'(dadc_mag[DDW-1:0]) << SH;
    assign den_half = den_full >> 1;
    assign num2 = {1'b0, num_mag[MW-1:0]} + (MW+1)'(den_half);

    // restoring divide step
    assign rem_sh = {r_rem, r_quo[DVW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_div};

    // signed result and clamp
    assign base = SW'(i_cal.psi_low) <<< 8;
    assign qs   = r_neg ? -signed'(SW'(r_quo)) : signed'(SW'(r_quo));
    assign psum = base + qs;

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        n_sample = r_sample;
        n_level  = r_level;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_div    = r_div;
        n_neg    = r_neg;
        n_press  = r_press;
        n_err    = r_err;
        if (i_ctrl.load_sample) begin
            n_sample = i_adc_sample;
        end
        unique case (i_ctrl.op)
            emac_pkg::OP_NONE: ;
            emac_pkg::OP_MUL_OLD: begin
                mul_a = signed'(OW'(r_level));
                mul_b = emac_pkg::ALPHA_Q;
            end
            emac_pkg::OP_MUL_NEW: begin
                n_acc = prod[AW-1:0];
                mul_a = signed'(OW'(r_sample));
                mul_b = emac_pkg::BETA_Q;
            end
            emac_pkg::OP_LEVEL: begin
                n_level = acc_sum[AW-1:emac_pkg::WEIGHT_SHIFT];
                n_err   = calib_err;
                n_press = '0;
            end
            emac_pkg::OP_MUL_CAL: begin
                mul_a = off;
                mul_b = emac_pkg::MUL_B_W'(dpsi);
            end
            emac_pkg::OP_PREP: begin
                n_neg = num[NW-1] ^ dadc[DDW];
                n_div = dadc_mag[DDW-1:0];
                n_rem = '0;
                n_quo = num2[MW:SH];
            end
            emac_pkg::OP_DIV: begin
                if (!trial[DDW+1]) begin
                    n_rem = trial[DDW-1:0];
                    n_quo = {r_quo[DVW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[DDW-1:0];
                    n_quo = {r_quo[DVW-2:0], 1'b0};
                end
            end
            emac_pkg::OP_FINAL: begin
                if (psum > SAT_HI) begin
                    n_press = SAT_HI[emac_pkg::Q8_W-1:0];
                end else if (psum < SAT_LO) begin
                    n_press = SAT_LO[emac_pkg::Q8_W-1:0];
                end else begin
                    n_press = psum[emac_pkg::Q8_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RST;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_div    <= n_div;
        r_neg    <= n_neg;
        r_press  <= n_press;
        r_err    <= n_err;
    end

    assign o_stat.calib_err = calib_err;
    assign o_sample         = r_sample;
    assign o_level          = r_level;
    assign o_press          = r_press;
    assign o_err            = r_err;

endmodule

// ----- rtl/ema_filtered_two_point_calibration.sv -----
// sequence: MUL_OLD, MUL_NEW, LEVEL, MUL_CAL, PREP, one DIV step per quotient bit (Q = 33 by default), FINAL, DONE;
// equal calibration readings go straight from LEVEL to DONE
// one item at a time, limited by the bit-serial restoring divider
// and the single shared multiplier; input stalls from acceptance until the result is handed off
// reset (synchronous, active low): filter level 512.0, calibration registers at their defaults
module ema_filtered_two_point_calibration #(
    parameter int SAMPLE_BITS      = emac_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = emac_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input transaction
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [SAMPLE_BITS-1:0]                  i_adc_sample,
    // result transaction
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [SAMPLE_BITS-1:0]                  o_raw_sample,
    output logic [SAMPLE_BITS+FILTER_FRAC_BITS-1:0] o_filtered_level,
    output logic signed [emac_pkg::Q8_W-1:0]        o_pressure_q8,
    output logic                                    o_calib_error,
    // calibration register writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [emac_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [emac_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int LW = SAMPLE_BITS + FILTER_FRAC_BITS;

    emac_pkg::t_cal  r_cal;
    emac_pkg::t_ctrl ctrl;
    emac_pkg::t_stat stat;

    logic [SAMPLE_BITS-1:0]           dp_sample;
    logic [LW-1:0]                    dp_level;
    logic signed [emac_pkg::Q8_W-1:0] dp_press;
    logic                             dp_err;
    logic                             out_busy;

    logic                             r_out_valid;
    logic [SAMPLE_BITS-1:0]           r_raw;
    logic [LW-1:0]                    r_filt;
    logic signed [emac_pkg::Q8_W-1:0] r_press;
    logic                             r_err;

    // config writes always taken; the contract keeps them to idle periods
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.adc_low  <= emac_pkg::ADC_LOW_RST;
            r_cal.psi_low  <= emac_pkg::PSI_LOW_RST;
            r_cal.adc_high <= emac_pkg::ADC_HIGH_RST;
            r_cal.psi_high <= emac_pkg::PSI_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (emac_pkg::t_cfg_idx'(i_cfg_index))
                emac_pkg::CFG_ADC_LOW:  r_cal.adc_low  <= i_cfg_data[emac_pkg::ADC_CAL_W-1:0];
                emac_pkg::CFG_PSI_LOW:  r_cal.psi_low  <= signed'(i_cfg_data);
                emac_pkg::CFG_ADC_HIGH: r_cal.adc_high <= i_cfg_data[emac_pkg::ADC_CAL_W-1:0];
                emac_pkg::CFG_PSI_HIGH: r_cal.psi_high <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // output register holds a result that has not been taken
    assign out_busy = r_out_valid && i_out_stall;

    // sequencer: filter multiplies, line multiply, divide steps, clamp
    emac_ctrl #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
    ) u_emac_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    // datapath around the shared multiplier and the divide step
    emac_dp #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
    ) u_emac_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cal        (r_cal),
        .i_adc_sample (i_adc_sample),
        .o_stat       (stat),
        .o_sample     (dp_sample),
        .o_level      (dp_level),
        .o_press      (dp_press),
        .o_err        (dp_err)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_out) begin
            r_raw   <= dp_sample;
            r_filt  <= dp_level;
            r_press <= dp_press;
            r_err   <= dp_err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_raw_sample     = r_raw;
    assign o_filtered_level = r_filt;
    assign o_pressure_q8    = r_press;
    assign o_calib_error    = r_err;

endmodule

// ----- rtl/emac_chk.sv -----
module emac_chk #(
    parameter int SAMPLE_BITS      = emac_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = emac_pkg::FILTER_FRAC_BITS_DEF
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_in_valid,
    input logic                                    o_in_stall,
    input logic                                    o_out_valid,
    input logic                                    i_out_stall,
    input logic [SAMPLE_BITS+FILTER_FRAC_BITS-1:0] o_filtered_level,
    input logic signed [emac_pkg::Q8_W-1:0]        o_pressure_q8,
    input logic                                    o_calib_error
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pressure_q8) && $stable(o_filtered_level))
        else $error("stalled result changed");

    // one item at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before item finished");

    // a new result only comes out of a busy sequencer
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

    // equal calibration readings force zero pressure
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_calib_error |-> o_pressure_q8 == '0)
        else $error("pressure not zero on calibration error");

endmodule

bind ema_filtered_two_point_calibration emac_chk #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
) u_emac_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_filtered_level (o_filtered_level),
    .o_pressure_q8    (o_pressure_q8),
    .o_calib_error    (o_calib_error)
);
